>>> rtl/core/ndft_pkg.sv
`timescale 1ns / 1ps

package ndft_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int POS_W       = 16;
    localparam int SMP_W       = 16;
    localparam int ACC_W       = 40;
    localparam int PROD_W      = 32;
    localparam int PHASE_W     = 16;
    localparam int TIDX_W      = 8;
    localparam int QTR_W       = 6;
    localparam int RAM_W       = POS_W + SMP_W;

    localparam logic [15:0] QUARTER_SINE [0:64] = '{
        16'd0,     16'd804,   16'd1608,  16'd2410,  16'd3212,  16'd4011,  16'd4808,
        16'd5602,  16'd6393,  16'd7179,  16'd7962,  16'd8739,  16'd9512,  16'd10278,
        16'd11039, 16'd11793, 16'd12539, 16'd13279, 16'd14010, 16'd14732, 16'd15446,
        16'd16151, 16'd16846, 16'd17530, 16'd18204, 16'd18868, 16'd19519, 16'd20159,
        16'd20787, 16'd21403, 16'd22005, 16'd22594, 16'd23170, 16'd23731, 16'd24279,
        16'd24811, 16'd25329, 16'd25832, 16'd26319, 16'd26790, 16'd27245, 16'd27683,
        16'd28105, 16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956, 16'd30273,
        16'd30571, 16'd30852, 16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971,
        16'd32137, 16'd32285, 16'd32412, 16'd32521, 16'd32609, 16'd32678, 16'd32728,
        16'd32757, 16'd32767
    };

    typedef struct packed {
        logic [POS_W-1:0]        position_frac;
        logic signed [SMP_W-1:0] sample_value;
        logic                    last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [ACC_W-1:0] real_part;
        logic signed [ACC_W-1:0] imag_part;
        logic                    last_result;
    } t_out_item;

    typedef struct packed {
        logic             clear;
        logic             term_valid;
        logic [IDX_W-1:0] k;
    } t_mac_ctrl;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    // sine on a 256-point circle, Q1.15
    function automatic logic signed [15:0] sine_at(input logic [TIDX_W-1:0] idx);
        logic [1:0]       q;
        logic [QTR_W-1:0] r;
        logic [QTR_W:0]   ri;
        logic [15:0]      v;
        q  = idx[TIDX_W-1:TIDX_W-2];
        r  = idx[QTR_W-1:0];
        ri = q[0] ? (7'd64 - {1'b0, r}) : {1'b0, r};
        v  = QUARTER_SINE[ri];
        return q[1] ? -$signed(v) : $signed(v);
    endfunction

endpackage

>>> rtl/core/nonuniform_dft_engine_unit.sv
`timescale 1ns / 1ps

// channel | direction | handshake                   | payload
// in      | input     | i_in_valid / o_in_ready     | i_in_data  (t_in_item)
// out     | output    | o_out_valid / i_out_ready   | o_out_data (t_out_item)
//
// each sample transfer is stored; nothing is emitted until the set closes
// a set of n samples then yields n bins, computed one after another:
//   each bin streams n terms from the sample ram through one shared complex mac
// the input is not ready from the closing sample until the last bin is transferred
// synchronous active-low reset clears the fsm, counters and valid flags only
// a stalled output holds the engine; the next bin starts after its transfer

module nonuniform_dft_engine_unit import ndft_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_last_idx;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_k;
    logic             r_rd_valid;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic             w_in_fire;
    logic             w_out_fire;
    logic             w_start;
    logic             w_drain_done;
    logic [RAM_W-1:0] w_rdata;
    t_mac_ctrl        w_mac_ctrl;
    logic signed [ACC_W-1:0] w_acc_re, w_acc_im;
    logic             w_mac_busy;

    assign o_in_ready = (r_state == ST_LOAD);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_fire = r_out_valid && i_out_ready;
    // a sample landing in the final entry closes the set even when unmarked
    assign w_start    = w_in_fire && (i_in_data.last_sample ||
                        (r_count[IDX_W-1:0] == IDX_W'(MAX_SAMPLES - 1)));
    assign w_drain_done = (r_state == ST_DRAIN) && !r_rd_valid && !w_mac_busy;

    ndft_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_in_fire),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({i_in_data.position_frac, i_in_data.sample_value}),
        .i_re    (r_state == ST_RUN),
        .i_raddr (r_j),
        .o_rdata (w_rdata)
    );

    assign w_mac_ctrl.clear      = w_start ||
                                   (w_out_fire && !r_out_data.last_result);
    assign w_mac_ctrl.term_valid = r_rd_valid;
    assign w_mac_ctrl.k          = r_k;

    ndft_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_mac_ctrl),
        .i_term   (w_rdata),
        .o_acc_re (w_acc_re),
        .o_acc_im (w_acc_im),
        .o_busy   (w_mac_busy)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_start) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (r_j == r_last_idx) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (w_drain_done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_fire) n_state = r_out_data.last_result ? ST_LOAD : ST_RUN;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= (r_state == ST_RUN);
            if (w_start) begin
                r_count <= '0;
            end else if (w_in_fire) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_start || w_out_fire) begin
                r_j <= '0;
            end else if (r_state == ST_RUN) begin
                r_j <= r_j + IDX_W'(1);
            end
            if (w_start) begin
                r_k <= '0;
            end else if (w_out_fire) begin
                r_k <= r_k + IDX_W'(1);
            end
            if (w_drain_done) begin
                r_out_valid <= 1'b1;
            end else if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_last_idx <= r_count[IDX_W-1:0];
        end
        if (w_drain_done) begin
            r_out_data.real_part   <= w_acc_re;
            r_out_data.imag_part   <= w_acc_im;
            r_out_data.last_result <= (r_k == r_last_idx);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> (r_k <= r_last_idx))
        else $error("bin index past end of set");

    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && r_out_data.last_result) |=> o_in_ready)
        else $error("input not reopened after final bin");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!o_in_ready && !r_rd_valid && !w_mac_busy))
        else $error("result pending while engine active");

    a_drain_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (!r_rd_valid && !w_mac_busy))
        else $error("terms in flight at start of set");

endmodule

>>> rtl/core/ndft_ram.sv
`timescale 1ns / 1ps

module ndft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ndft_mac.sv
`timescale 1ns / 1ps

module ndft_mac import ndft_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_ctrl               i_ctrl,
    input  logic [RAM_W-1:0]        i_term,
    output logic signed [ACC_W-1:0] o_acc_re,
    output logic signed [ACC_W-1:0] o_acc_im,
    output logic                    o_busy
);

    logic [POS_W-1:0]          w_pos;
    logic signed [SMP_W-1:0]   w_y;
    logic [IDX_W+POS_W-1:0]    w_phase_full;
    logic [PHASE_W-1:0]        w_phase_rnd;

    logic                      r_v1, r_v2, r_v3;
    logic [TIDX_W-1:0]         r_idx;
    logic signed [SMP_W-1:0]   r_y1, r_y2;
    logic signed [15:0]        r_cos, r_sin;
    logic signed [PROD_W-1:0]  r_pc, r_ps;
    logic signed [ACC_W-1:0]   r_acc_re, r_acc_im;

    assign w_pos        = i_term[RAM_W-1:SMP_W];
    assign w_y          = $signed(i_term[SMP_W-1:0]);
    assign w_phase_full = i_ctrl.k * w_pos;
    // round to the nearest of 256 points, ties up, wrapping on the circle
    assign w_phase_rnd  = w_phase_full[PHASE_W-1:0] + PHASE_W'(128);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctrl.term_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: phase index
        r_idx <= w_phase_rnd[PHASE_W-1:PHASE_W-TIDX_W];
        r_y1  <= w_y;
        // stage 2: table lookup
        r_cos <= sine_at(r_idx + TIDX_W'(64));
        r_sin <= sine_at(r_idx);
        r_y2  <= r_y1;
        // stage 3: products
        r_pc  <= r_y2 * r_cos;
        r_ps  <= r_y2 * r_sin;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v3) begin
            r_acc_re <= r_acc_re + ACC_W'(r_pc);
            r_acc_im <= r_acc_im + ACC_W'(r_ps);
        end
    end

    assign o_acc_re = r_acc_re;
    assign o_acc_im = r_acc_im;
    assign o_busy   = r_v1 | r_v2 | r_v3;

endmodule
